### rtl/mcr_pkg.sv
// Shared types and constants for the Muskingum-Cunge routing block.
// Used by mcr_mul, mcr_div and muskingum_cunge_routing_step; no dependencies.
package mcr_pkg;

	localparam int unsigned RemW = 100;
	localparam int unsigned QuoW = 64;
	localparam int unsigned AccW = 128;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CLIP = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	localparam logic [1:0] CFG_WIDTH = 2'd0;
	localparam logic [1:0] CFG_SLOPE = 2'd1;
	localparam logic [1:0] CFG_REACH = 2'd2;

	localparam logic [62:0] D_CAP   = 63'h4000_0000_0000_0000;
	localparam logic [62:0] TWO_Q32 = 63'h0000_0002_0000_0000;

	typedef struct packed {
		logic              valid;
		logic signed [32:0] a;
		logic signed [32:0] b;
		logic [1:0]        shift;
		logic              clear;
	} mul_op_t;

	typedef struct packed {
		logic            start;
		logic [RemW-1:0] rem_init;
		logic [RemW-1:0] dvsr;
		logic [QuoW-1:0] low;
		logic [6:0]      steps;
	} div_cmd_t;

endpackage

### rtl/mcr_mul.sv
// Shared signed 33x33 multiplier with a registered product and a 128-bit
// shifting accumulator. Depends on mcr_pkg.
module mcr_mul import mcr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  mul_op_t             op,
	output logic [AccW-1:0]     acc
);
	logic signed [65:0] p_s1;
	logic [1:0]         sh_s1;
	logic               clr_s1;
	logic               v_s1;
	logic [AccW-1:0]    acc_q;
	logic [AccW-1:0]    ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= op.a * op.b;
		sh_s1  <= op.shift;
		clr_s1 <= op.clear;
		if (v_s1) begin
			acc_q <= (clr_s1 ? '0 : acc_q) + (ext << {sh_s1, 5'b0});
		end
	end

	assign ext = {{(AccW-66){p_s1[65]}}, p_s1};
	assign acc = acc_q;

endmodule

### rtl/mcr_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on mcr_pkg for the command type.
module mcr_div import mcr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  div_cmd_t        cmd,
	output logic            busy,
	output logic [QuoW-1:0] quo,
	output logic [RemW-1:0] rem
);
	logic [RemW-1:0] rem_q;
	logic [RemW-1:0] dvsr_q;
	logic [QuoW-1:0] low_q;
	logic [QuoW-1:0] quo_q;
	logic [6:0]      cnt_q;
	logic            busy_q;
	logic [RemW:0]   rem2;
	logic [RemW:0]   diff;
	logic            ge;

	assign rem2 = {rem_q, low_q[QuoW-1]};
	assign diff = rem2 - {1'b0, dvsr_q};
	assign ge   = rem2 >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= cmd.rem_init;
			dvsr_q <= cmd.dvsr;
			low_q  <= cmd.low;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RemW-1:0] : rem2[RemW-1:0];
			low_q <= {low_q[QuoW-2:0], 1'b0};
			quo_q <= {quo_q[QuoW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

### rtl/muskingum_cunge_routing_step.sv
// Top level of the Muskingum-Cunge routing step: sequencer around a shared
// multiplier (mcr_mul) and a shared divider (mcr_div). Depends on mcr_pkg.
//
// Usage: one input item per routing time step on the in_ channel, one result
// item per input on the out_ channel, both valid/ready. Registers are written
// on the cfg_ channel (index 0 width, 1 slope, 2 reach length); the user must
// write them only while idle, the block itself does not enforce this.
// An item is taken only while the sequencer is idle. It first computes the
// substep length on the multiplier and the substep count with one 48-step
// division, then w*s*c, then for each distinct sublength (zero, one or two of
// them) the denominator, D and both coefficients, dominated by the 64-step D
// division (that division is skipped when D saturates). Each substep then
// takes three products on the shared multiplier. A zero celerity item skips
// this and finishes with hold status. The next item can be taken in the
// cycle after the result is loaded into the output register.
// The result waits in an output register; a stalled receiver holds it there
// and the block takes the next item, but finishes it only once that register
// is free. Reset clears the previous outflow to zero and loads the register
// defaults (10 m width, slope 0.001, 10000 m reach).
module muskingum_cunge_routing_step import mcr_pkg::*; #(
	parameter int unsigned MAX_SUBSTEPS = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [30:0]        inflow_now,
	input  logic [30:0]        inflow_next,
	input  logic [31:0]        celerity,
	input  logic               first_step,
	input  logic signed [31:0] start_outflow,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] outflow_next,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam int unsigned CntW = 16;
	localparam logic [CntW-1:0] MaxSub = CntW'(MAX_SUBSTEPS);

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_MUL, S_MWAIT, S_MPOST, S_DIV, S_DWAIT, S_DPOST,
		S_LEN, S_DCHK, S_DONE
	} state_t;

	typedef enum logic [2:0] {J_DQ, J_WS, J_WSC, J_DEN, J_SUB} job_t;
	typedef enum logic [1:0] {DV_NR, DV_D, DV_C0, DV_C1} dj_t;

	state_t             state_q;
	job_t               job_q;
	dj_t                dj_q;
	logic [1:0]         mcnt_q;
	logic [1:0]         mlast;
	logic [31:0]        width_q, slope_q;
	logic [23:0]        reach_q;
	logic [31:0]        cel_q;
	logic [30:0]        inflow_q, inext_q;
	logic signed [31:0] fin_q, fout_q, prev_q;
	logic [43:0]        dq_q, r_q, len_q;
	logic [CntW-1:0]    nsub_q, k_q;
	logic               left_q, full_q, cur_full_q;
	logic [63:0]        ws_q;
	logic [55:0]        wsc_q;
	logic [99:0]        den_q;
	logic [62:0]        d_q;
	logic [30:0]        c0_q;
	logic [31:0]        c1_q;
	logic [1:0]         st_q;
	logic               out_valid_q;
	logic signed [31:0] out_q;
	logic [1:0]         out_st_q;

	mul_op_t            mop;
	div_cmd_t           dcmd;
	logic [AccW-1:0]    acc;
	logic               div_busy;
	logic [QuoW-1:0]    quo;
	logic [RemW-1:0]    rem;
	logic [62:0]        xmag;
	logic signed [66:0] v;
	logic signed [36:0] qv;
	logic signed [31:0] sat;
	logic [CntW:0]      k_next;

	mcr_mul u_mul (.clk(clk), .arst_n(arst_n), .op(mop), .acc(acc));
	mcr_div u_div (.clk(clk), .arst_n(arst_n), .cmd(dcmd), .busy(div_busy),
		.quo(quo), .rem(rem));

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign outflow_next = out_q;
	assign status    = out_st_q;

	assign xmag = (d_q <= TWO_Q32) ? (TWO_Q32 - d_q) : (d_q - TWO_Q32);
	assign v    = $signed(acc[66:0]) + 67'sd536870912;
	assign qv   = v[66:30];
	assign k_next = {1'b0, k_q} + 17'd1;

	always_comb begin
		if (qv > 37'sd2147483647) begin
			sat = 32'sh7fff_ffff;
		end else if (qv < -37'sd2147483648) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = qv[31:0];
		end
	end

	always_comb begin
		case (job_q)
			J_WSC:   mlast = 2'd1;
			J_DEN:   mlast = 2'd3;
			J_SUB:   mlast = 2'd2;
			default: mlast = 2'd0;
		endcase
	end

	always_comb begin
		mop = '0;
		mop.valid = (state_q == S_MUL);
		mop.clear = (mcnt_q == 2'd0);
		case (job_q)
			J_DQ: begin
				mop.a = {1'b0, cel_q};
				mop.b = 33'sd3600;
			end
			J_WS: begin
				mop.a = {1'b0, width_q};
				mop.b = {1'b0, slope_q};
			end
			J_WSC: begin
				mop.a = (mcnt_q == 2'd0) ? {1'b0, ws_q[31:0]} : {1'b0, ws_q[63:32]};
				mop.b = {1'b0, cel_q};
				mop.shift = (mcnt_q == 2'd0) ? 2'd0 : 2'd1;
			end
			J_DEN: begin
				mop.a = mcnt_q[1] ? {9'b0, wsc_q[55:32]} : {1'b0, wsc_q[31:0]};
				mop.b = mcnt_q[0] ^ mcnt_q[1] ? ((mcnt_q == 2'd1) ?
					{21'b0, len_q[43:32]} : {1'b0, len_q[31:0]}) :
					((mcnt_q == 2'd0) ? {1'b0, len_q[31:0]} : {21'b0, len_q[43:32]});
				mop.shift = {1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]};
			end
			J_SUB: begin
				case (mcnt_q)
					2'd0: begin
						mop.a = {2'b0, c0_q};
						mop.b = {2'b0, inext_q};
					end
					2'd1: begin
						mop.a = {c1_q[31], c1_q};
						mop.b = {fin_q[31], fin_q};
					end
					default: begin
						mop.a = {2'b0, c0_q};
						mop.b = {fout_q[31], fout_q};
					end
				endcase
			end
			default: begin
				mop.a = '0;
				mop.b = '0;
			end
		endcase
	end

	always_comb begin
		dcmd = '0;
		dcmd.start = (state_q == S_DIV);
		case (dj_q)
			DV_NR: begin
				dcmd.dvsr  = {56'b0, dq_q};
				dcmd.low   = {reach_q, 40'b0};
				dcmd.steps = 7'd48;
			end
			DV_D: begin
				dcmd.rem_init = {57'b0, inflow_q, 12'b0};
				dcmd.dvsr     = den_q;
				dcmd.steps    = 7'd64;
			end
			DV_C0: begin
				dcmd.rem_init = {38'b0, d_q[62:1]};
				dcmd.dvsr     = {37'b0, TWO_Q32 + d_q};
				dcmd.low      = {d_q[0], 63'b0};
				dcmd.steps    = 7'd31;
			end
			default: begin
				dcmd.rem_init = {38'b0, xmag[62:1]};
				dcmd.dvsr     = {37'b0, TWO_Q32 + d_q};
				dcmd.low      = {xmag[0], 63'b0};
				dcmd.steps    = 7'd31;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= J_DQ;
			dj_q        <= DV_NR;
			mcnt_q      <= '0;
			width_q     <= 32'd655360;
			slope_q     <= 32'd4294967;
			reach_q     <= 24'd10000;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
			left_q      <= 1'b0;
			full_q      <= 1'b0;
			cur_full_q  <= 1'b0;
			k_q         <= '0;
			nsub_q      <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_WIDTH: width_q <= cfg_data;
					CFG_SLOPE: slope_q <= cfg_data;
					CFG_REACH: reach_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						inflow_q <= inflow_now;
						inext_q  <= inflow_next;
						cel_q    <= celerity;
						fin_q    <= {1'b0, inflow_now};
						fout_q   <= first_step ? start_outflow : prev_q;
						st_q     <= ST_OK;
						state_q  <= S_CHK;
					end
				end
				S_CHK: begin
					if (cel_q == 32'd0) begin
						st_q    <= ST_HOLD;
						state_q <= S_DONE;
					end else begin
						job_q   <= J_DQ;
						mcnt_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mcnt_q == mlast) begin
						state_q <= S_MWAIT;
					end else begin
						mcnt_q <= mcnt_q + 2'd1;
					end
				end
				S_MWAIT: state_q <= S_MPOST;
				S_MPOST: begin
					mcnt_q <= '0;
					case (job_q)
						J_DQ: begin
							dq_q    <= acc[43:0];
							dj_q    <= DV_NR;
							state_q <= S_DIV;
						end
						J_WS: begin
							ws_q    <= acc[63:0];
							job_q   <= J_WSC;
							state_q <= S_MUL;
						end
						J_WSC: begin
							wsc_q   <= acc[95:40];
							state_q <= S_LEN;
						end
						J_DEN: begin
							den_q   <= acc[99:0];
							state_q <= S_DCHK;
						end
						default: begin
							fin_q  <= sat;
							fout_q <= sat;
							k_q    <= k_next[CntW-1:0];
							if (cur_full_q && (k_next < {1'b0, nsub_q})) begin
								state_q <= S_MUL;
							end else begin
								state_q <= S_LEN;
							end
						end
					endcase
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (!div_busy) begin
						state_q <= S_DPOST;
					end
				end
				S_DPOST: begin
					case (dj_q)
						DV_NR: begin
							r_q <= rem[43:0];
							if (quo[47:0] > {32'b0, MaxSub}) begin
								nsub_q <= MaxSub;
								full_q <= 1'b1;
								left_q <= 1'b0;
								st_q   <= ST_CLIP;
							end else begin
								nsub_q <= quo[CntW-1:0];
								full_q <= (quo[47:0] != 48'd0);
								left_q <= (rem[43:0] != 44'd0);
							end
							job_q   <= J_WS;
							mcnt_q  <= '0;
							state_q <= S_MUL;
						end
						DV_D: begin
							d_q     <= (quo > {1'b0, D_CAP}) ? D_CAP : quo[62:0];
							dj_q    <= DV_C0;
							state_q <= S_DIV;
						end
						DV_C0: begin
							c0_q    <= quo[30:0];
							dj_q    <= DV_C1;
							state_q <= S_DIV;
						end
						default: begin
							c1_q    <= (d_q <= TWO_Q32) ? {1'b0, quo[30:0]} :
								(32'd0 - {1'b0, quo[30:0]});
							k_q     <= '0;
							job_q   <= J_SUB;
							mcnt_q  <= '0;
							state_q <= S_MUL;
						end
					endcase
				end
				S_LEN: begin
					mcnt_q <= '0;
					job_q  <= J_DEN;
					if (full_q) begin
						full_q     <= 1'b0;
						cur_full_q <= 1'b1;
						len_q      <= dq_q;
						state_q    <= S_MUL;
					end else if (left_q) begin
						left_q     <= 1'b0;
						cur_full_q <= 1'b0;
						len_q      <= r_q;
						state_q    <= S_MUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DCHK: begin
					if (den_q == 100'd0 || {57'b0, inflow_q, 12'b0} >= den_q) begin
						d_q     <= D_CAP;
						dj_q    <= DV_C0;
					end else begin
						dj_q    <= DV_D;
					end
					state_q <= S_DIV;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= fout_q;
						out_st_q    <= st_q;
						prev_q      <= fout_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("Result item appeared without the sequencer finishing.");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_busy)
		else $error("Divider still running while the block is idle.");

	a_sub_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && job_q == J_SUB && cur_full_q) |-> (k_q < nsub_q))
		else $error("Full substep count exceeded.");

	a_hold_zero_cel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && cel_q == 32'd0) |=> (state_q == S_DONE && st_q == ST_HOLD))
		else $error("Zero celerity item did not take the hold path.");

endmodule
